// ===== design/tr2rp_pkg.sv =====
package tr2rp_pkg;

    localparam int KindW = 4;
    localparam int RoleW = 4;

    localparam logic [KindW-1:0] KIND_RDCH    = 4'd0;
    localparam logic [KindW-1:0] KIND_CLI     = 4'd1;
    localparam logic [KindW-1:0] KIND_BYTELO  = 4'd2;
    localparam logic [KindW-1:0] KIND_BYTEHI  = 4'd3;
    localparam logic [KindW-1:0] KIND_WORD    = 4'd4;
    localparam logic [KindW-1:0] KIND_WORD0   = 4'd5;
    localparam logic [KindW-1:0] KIND_ARGS    = 4'd6;
    localparam logic [KindW-1:0] KIND_BGET    = 4'd7;
    localparam logic [KindW-1:0] KIND_BPUT    = 4'd8;
    localparam logic [KindW-1:0] KIND_FIND    = 4'd9;
    localparam logic [KindW-1:0] KIND_FILE    = 4'd10;
    localparam logic [KindW-1:0] KIND_GBPB    = 4'd11;
    localparam logic [KindW-1:0] KIND_ILLEGAL = 4'd12;

    localparam logic [RoleW-1:0] ROLE_OP     = 4'd0;
    localparam logic [RoleW-1:0] ROLE_A      = 4'd1;
    localparam logic [RoleW-1:0] ROLE_X      = 4'd2;
    localparam logic [RoleW-1:0] ROLE_Y      = 4'd3;
    localparam logic [RoleW-1:0] ROLE_INLEN  = 4'd4;
    localparam logic [RoleW-1:0] ROLE_OUTLEN = 4'd5;
    localparam logic [RoleW-1:0] ROLE_BLK    = 4'd6;
    localparam logic [RoleW-1:0] ROLE_STR    = 4'd7;
    localparam logic [RoleW-1:0] ROLE_TERM   = 4'd8;

    localparam logic [7:0] OP_RDCH   = 8'h00;
    localparam logic [7:0] OP_CLI    = 8'h02;
    localparam logic [7:0] OP_BYTELO = 8'h04;
    localparam logic [7:0] OP_BYTEHI = 8'h06;
    localparam logic [7:0] OP_WORD   = 8'h08;
    localparam logic [7:0] OP_WORD0  = 8'h0A;
    localparam logic [7:0] OP_ARGS   = 8'h0C;
    localparam logic [7:0] OP_BGET   = 8'h0E;
    localparam logic [7:0] OP_BPUT   = 8'h10;
    localparam logic [7:0] OP_FIND   = 8'h12;
    localparam logic [7:0] OP_FILE   = 8'h14;
    localparam logic [7:0] OP_GBPB   = 8'h16;
    localparam logic [7:0] CHAR_CR   = 8'h0D;

    localparam logic [8:0] POS_MAX = 9'd511;

endpackage

// ===== design/tube_r2_request_parser.sv =====
// R2 request parser.
// Input channel: byte_in with in_valid/in_stall; one transaction per byte
// written by the parasite to the R2 request register.
// Output channel: req_kind, byte_role, byte_value, block_pos, end_of_request
// and illegal_opcode with out_valid/out_stall; exactly one result
// transaction per input transaction, in order.
// Result: registered, and valid in the cycle after the input transaction.
// Throughput: one byte per cycle while no result is held by out_stall; the
// parser state and the result register are both updated in the cycle that accepts the byte.
// Stall: while a result is held by out_stall, in_stall is raised and the
// parser state does not advance; a result register slot that is being
// drained in the same cycle does not block a new byte.
// Reset: parser goes idle, position count and word in-length clear, no
// result is pending.
// Illegal opcodes are tagged and leave the parser idle.
module tube_r2_request_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    byte_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tr2rp_pkg::KindW-1:0]   req_kind,
    output logic [tr2rp_pkg::RoleW-1:0]   byte_role,
    output logic [7:0]                    byte_value,
    output logic [7:0]                    block_pos,
    output logic                          end_of_request,
    output logic                          illegal_opcode
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLI, ST_BLO_X, ST_BLO_A, ST_BHI_X, ST_BHI_Y, ST_BHI_A,
        ST_W_A, ST_W_LEN, ST_W_BLK, ST_W_OUT, ST_W0_BLK, ST_ARG_Y, ST_ARG_BLK,
        ST_ARG_A, ST_BGET_Y, ST_BPUT_Y, ST_BPUT_A, ST_FIND_A, ST_FIND_Y,
        ST_FIND_STR, ST_FILE_BLK, ST_FILE_STR, ST_FILE_A, ST_GBPB_BLK, ST_GBPB_A
    } state_t;

    state_t                        state_reg, state_next;
    logic [8:0]                    pos_reg, pos_next;
    logic [7:0]                    wlen_reg, wlen_next;
    logic                          out_valid_reg;
    logic [tr2rp_pkg::KindW-1:0]   kind_reg, kind_next;
    logic [tr2rp_pkg::RoleW-1:0]   role_reg, role_next;
    logic [7:0]                    value_reg;
    logic [7:0]                    bpos_reg, bpos_next;
    logic                          end_reg, end_next;
    logic                          ill_reg, ill_next;

    logic                          in_accept;
    logic [8:0]                    pos;
    logic [7:0]                    pos_w, pos_w0, pos_arg, pos_blk16;

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign pos       = (pos_reg < tr2rp_pkg::POS_MAX) ? pos_reg + 9'd1 : pos_reg;
    assign pos_w     = pos[7:0] - 8'd4;
    assign pos_w0    = pos[7:0] - 8'd2;
    assign pos_arg   = pos[7:0] - 8'd3;
    assign pos_blk16 = pos[7:0] - 8'd2;

    always_comb
    begin
        state_next = state_reg;
        wlen_next  = wlen_reg;
        kind_next  = tr2rp_pkg::KIND_ILLEGAL;
        role_next  = tr2rp_pkg::ROLE_OP;
        bpos_next  = 8'd0;
        end_next   = 1'b0;
        ill_next   = 1'b0;

        case (state_reg)
            ST_CLI:
            begin
                kind_next = tr2rp_pkg::KIND_CLI;
                if (byte_in == tr2rp_pkg::CHAR_CR)
                begin
                    role_next  = tr2rp_pkg::ROLE_TERM;
                    end_next   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    role_next = tr2rp_pkg::ROLE_STR;
                end
            end
            ST_BLO_X:
            begin
                kind_next  = tr2rp_pkg::KIND_BYTELO;
                role_next  = tr2rp_pkg::ROLE_X;
                state_next = ST_BLO_A;
            end
            ST_BLO_A:
            begin
                kind_next  = tr2rp_pkg::KIND_BYTELO;
                role_next  = tr2rp_pkg::ROLE_A;
                end_next   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BHI_X:
            begin
                kind_next  = tr2rp_pkg::KIND_BYTEHI;
                role_next  = tr2rp_pkg::ROLE_X;
                state_next = ST_BHI_Y;
            end
            ST_BHI_Y:
            begin
                kind_next  = tr2rp_pkg::KIND_BYTEHI;
                role_next  = tr2rp_pkg::ROLE_Y;
                state_next = ST_BHI_A;
            end
            ST_BHI_A:
            begin
                kind_next  = tr2rp_pkg::KIND_BYTEHI;
                role_next  = tr2rp_pkg::ROLE_A;
                end_next   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_W_A:
            begin
                kind_next  = tr2rp_pkg::KIND_WORD;
                role_next  = tr2rp_pkg::ROLE_A;
                state_next = ST_W_LEN;
            end
            ST_W_LEN:
            begin
                kind_next  = tr2rp_pkg::KIND_WORD;
                role_next  = tr2rp_pkg::ROLE_INLEN;
                wlen_next  = byte_in;
                state_next = (byte_in != 8'd0) ? ST_W_BLK : ST_W_OUT;
            end
            ST_W_BLK:
            begin
                kind_next = tr2rp_pkg::KIND_WORD;
                role_next = tr2rp_pkg::ROLE_BLK;
                bpos_next = pos_w;
                if (pos == {1'b0, wlen_reg} + 9'd3)
                begin
                    state_next = ST_W_OUT;
                end
            end
            ST_W_OUT:
            begin
                kind_next  = tr2rp_pkg::KIND_WORD;
                role_next  = tr2rp_pkg::ROLE_OUTLEN;
                end_next   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_W0_BLK:
            begin
                kind_next = tr2rp_pkg::KIND_WORD0;
                role_next = tr2rp_pkg::ROLE_BLK;
                bpos_next = pos_w0;
                if (pos == 9'd6)
                begin
                    end_next   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ARG_Y:
            begin
                kind_next  = tr2rp_pkg::KIND_ARGS;
                role_next  = tr2rp_pkg::ROLE_Y;
                state_next = ST_ARG_BLK;
            end
            ST_ARG_BLK:
            begin
                kind_next = tr2rp_pkg::KIND_ARGS;
                role_next = tr2rp_pkg::ROLE_BLK;
                bpos_next = pos_arg;
                if (pos == 9'd6)
                begin
                    state_next = ST_ARG_A;
                end
            end
            ST_ARG_A:
            begin
                kind_next  = tr2rp_pkg::KIND_ARGS;
                role_next  = tr2rp_pkg::ROLE_A;
                end_next   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BGET_Y:
            begin
                kind_next  = tr2rp_pkg::KIND_BGET;
                role_next  = tr2rp_pkg::ROLE_Y;
                end_next   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BPUT_Y:
            begin
                kind_next  = tr2rp_pkg::KIND_BPUT;
                role_next  = tr2rp_pkg::ROLE_Y;
                state_next = ST_BPUT_A;
            end
            ST_BPUT_A:
            begin
                kind_next  = tr2rp_pkg::KIND_BPUT;
                role_next  = tr2rp_pkg::ROLE_A;
                end_next   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FIND_A:
            begin
                kind_next  = tr2rp_pkg::KIND_FIND;
                role_next  = tr2rp_pkg::ROLE_A;
                state_next = (byte_in == 8'd0) ? ST_FIND_Y : ST_FIND_STR;
            end
            ST_FIND_Y:
            begin
                kind_next  = tr2rp_pkg::KIND_FIND;
                role_next  = tr2rp_pkg::ROLE_Y;
                end_next   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FIND_STR:
            begin
                kind_next = tr2rp_pkg::KIND_FIND;
                if (byte_in == tr2rp_pkg::CHAR_CR)
                begin
                    role_next  = tr2rp_pkg::ROLE_TERM;
                    end_next   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    role_next = tr2rp_pkg::ROLE_STR;
                end
            end
            ST_FILE_BLK:
            begin
                kind_next = tr2rp_pkg::KIND_FILE;
                role_next = tr2rp_pkg::ROLE_BLK;
                bpos_next = pos_blk16;
                if (pos == 9'd17)
                begin
                    state_next = ST_FILE_STR;
                end
            end
            ST_FILE_STR:
            begin
                kind_next = tr2rp_pkg::KIND_FILE;
                if (byte_in == tr2rp_pkg::CHAR_CR)
                begin
                    role_next  = tr2rp_pkg::ROLE_TERM;
                    state_next = ST_FILE_A;
                end
                else
                begin
                    role_next = tr2rp_pkg::ROLE_STR;
                end
            end
            ST_FILE_A:
            begin
                kind_next  = tr2rp_pkg::KIND_FILE;
                role_next  = tr2rp_pkg::ROLE_A;
                end_next   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_GBPB_BLK:
            begin
                kind_next = tr2rp_pkg::KIND_GBPB;
                role_next = tr2rp_pkg::ROLE_BLK;
                bpos_next = pos_blk16;
                if (pos == 9'd17)
                begin
                    state_next = ST_GBPB_A;
                end
            end
            ST_GBPB_A:
            begin
                kind_next  = tr2rp_pkg::KIND_GBPB;
                role_next  = tr2rp_pkg::ROLE_A;
                end_next   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
                case (byte_in)
                    tr2rp_pkg::OP_RDCH:
                    begin
                        kind_next = tr2rp_pkg::KIND_RDCH;
                        end_next  = 1'b1;
                    end
                    tr2rp_pkg::OP_CLI:
                    begin
                        kind_next  = tr2rp_pkg::KIND_CLI;
                        state_next = ST_CLI;
                    end
                    tr2rp_pkg::OP_BYTELO:
                    begin
                        kind_next  = tr2rp_pkg::KIND_BYTELO;
                        state_next = ST_BLO_X;
                    end
                    tr2rp_pkg::OP_BYTEHI:
                    begin
                        kind_next  = tr2rp_pkg::KIND_BYTEHI;
                        state_next = ST_BHI_X;
                    end
                    tr2rp_pkg::OP_WORD:
                    begin
                        kind_next  = tr2rp_pkg::KIND_WORD;
                        state_next = ST_W_A;
                    end
                    tr2rp_pkg::OP_WORD0:
                    begin
                        kind_next  = tr2rp_pkg::KIND_WORD0;
                        state_next = ST_W0_BLK;
                    end
                    tr2rp_pkg::OP_ARGS:
                    begin
                        kind_next  = tr2rp_pkg::KIND_ARGS;
                        state_next = ST_ARG_Y;
                    end
                    tr2rp_pkg::OP_BGET:
                    begin
                        kind_next  = tr2rp_pkg::KIND_BGET;
                        state_next = ST_BGET_Y;
                    end
                    tr2rp_pkg::OP_BPUT:
                    begin
                        kind_next  = tr2rp_pkg::KIND_BPUT;
                        state_next = ST_BPUT_Y;
                    end
                    tr2rp_pkg::OP_FIND:
                    begin
                        kind_next  = tr2rp_pkg::KIND_FIND;
                        state_next = ST_FIND_A;
                    end
                    tr2rp_pkg::OP_FILE:
                    begin
                        kind_next  = tr2rp_pkg::KIND_FILE;
                        state_next = ST_FILE_BLK;
                    end
                    tr2rp_pkg::OP_GBPB:
                    begin
                        kind_next  = tr2rp_pkg::KIND_GBPB;
                        state_next = ST_GBPB_BLK;
                    end
                    default:
                    begin
                        kind_next = tr2rp_pkg::KIND_ILLEGAL;
                        ill_next  = 1'b1;
                    end
                endcase
            end
        endcase

        pos_next = (state_next == ST_IDLE) ? 9'd0 : pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= 9'd0;
            wlen_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg     <= state_next;
                pos_reg       <= pos_next;
                wlen_reg      <= wlen_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg  <= kind_next;
            role_reg  <= role_next;
            value_reg <= byte_in;
            bpos_reg  <= bpos_next;
            end_reg   <= end_next;
            ill_reg   <= ill_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign req_kind       = kind_reg;
    assign byte_role      = role_reg;
    assign byte_value     = value_reg;
    assign block_pos      = bpos_reg;
    assign end_of_request = end_reg;
    assign illegal_opcode = ill_reg;

endmodule
